### rtl/bmp_pkg.sv
// Shared types and constants of the mosaic pixelation block.
// Used by the front and back parts, the top level and the checker; depends on nothing else.
`default_nettype none

package bmp_pkg;

  // Width of one ARGB pixel.
  localparam int PIXEL_W = 32;

  // Queue depths between the front part, the back part and the result port.
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  // Configuration register reset values.
  localparam logic [6:0]  BLOCK_SIZE_RESET  = 7'd8;
  localparam logic [11:0] IMAGE_WIDTH_RESET = 12'd640;

  // Register indexes, taken from byte address bit 2.
  localparam logic REG_BLOCK_SIZE  = 1'b0;
  localparam logic REG_IMAGE_WIDTH = 1'b1;

  // What the back part does with one pixel.
  typedef enum logic [1:0] {
    KIND_HEAD,    // top-left pixel of a block: capture and store its color
    KIND_FOLLOW,  // rest of a block's first row: use the held color
    KIND_READ     // later rows of a block: fetch the color from the line store
  } kind_e;

  // Raw configuration register contents.
  typedef struct packed {
    logic [6:0]  block_size;
    logic [11:0] image_width;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/bmp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
`default_nettype none

module bmp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire  [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire  [WIDTH-1:0]          wdata_i,
  input  wire                       re_i,
  input  wire  [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/bmp_fifo.sv
// Small synchronous queue with empty flag and fill count.
// Stand-alone; used between the front and back parts and at the result port.
`default_nettype none

module bmp_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          push_i,
  input  wire  [WIDTH-1:0]             wdata_i,
  input  wire                          pop_i,
  output logic [WIDTH-1:0]             rdata_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d;
  logic [PW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             is_full;
  logic             do_push, do_pop;

  assign is_full = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign rdata_o = mem_q[rptr_q];

  assign do_push = push_i && !is_full;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and count update.
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH-1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH-1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

### rtl/bmp_front.sv
// Front part: raster position counters and per-pixel classification.
// Depends on bmp_pkg for the kind codes and the configuration struct.
`default_nettype none

module bmp_front #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_BLOCK = 64
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  bmp_pkg::cfg_t       cfg_i,
  input  wire                 accept_i,
  input  wire  [31:0]         pixel_color_i,
  input  wire                 frame_start_i,
  output logic [$bits(bmp_pkg::kind_e)+$clog2(MAX_WIDTH)+bmp_pkg::PIXEL_W-1:0] entry_o
);

  import bmp_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH+1);
  localparam int EXTW = (WW > 12) ? WW : 12;
  localparam int OW   = $clog2(MAX_BLOCK);
  localparam int BW   = $clog2(MAX_BLOCK+1);
  localparam int EXTB = (BW > 7) ? BW : 7;

  logic [CW-1:0]   col_q, col_d, col_c;
  logic [CW-1:0]   idx_q, idx_d, idx_c;
  logic [OW-1:0]   offx_q, offx_d, offx_c;
  logic [OW-1:0]   offy_q, offy_d, offy_c;
  logic [EXTW-1:0] width_ext, eff_w;
  logic [EXTB-1:0] bs_ext, eff_bs;
  kind_e           kind;

  // Effective block size and line width after clamping.
  always_comb begin
    bs_ext = EXTB'(cfg_i.block_size);
    if (bs_ext == '0) begin
      eff_bs = EXTB'(1);
    end else if (bs_ext > EXTB'(MAX_BLOCK)) begin
      eff_bs = EXTB'(MAX_BLOCK);
    end else begin
      eff_bs = bs_ext;
    end
    width_ext = EXTW'(cfg_i.image_width);
    if (width_ext == '0) begin
      eff_w = EXTW'(1);
    end else if (width_ext > EXTW'(MAX_WIDTH)) begin
      eff_w = EXTW'(MAX_WIDTH);
    end else begin
      eff_w = width_ext;
    end
  end

  // A frame-start mark clears the counters before this pixel is used.
  assign col_c  = frame_start_i ? '0 : col_q;
  assign idx_c  = frame_start_i ? '0 : idx_q;
  assign offx_c = frame_start_i ? '0 : offx_q;
  assign offy_c = frame_start_i ? '0 : offy_q;

  // Classify the pixel by its place in the block.
  always_comb begin
    if (offy_c != '0) begin
      kind = KIND_READ;
    end else if (offx_c == '0) begin
      kind = KIND_HEAD;
    end else begin
      kind = KIND_FOLLOW;
    end
  end

  assign entry_o = {kind, idx_c, pixel_color_i};

  // Advance the raster position after each accepted pixel.
  always_comb begin
    col_d  = col_q;
    idx_d  = idx_q;
    offx_d = offx_q;
    offy_d = offy_q;
    if (accept_i) begin
      if ((EXTW'(col_c) + EXTW'(1)) >= eff_w) begin
        col_d  = '0;
        offx_d = '0;
        idx_d  = '0;
        if ((EXTB'(offy_c) + EXTB'(1)) >= eff_bs) begin
          offy_d = '0;
        end else begin
          offy_d = offy_c + OW'(1);
        end
      end else begin
        col_d  = col_c + CW'(1);
        offy_d = offy_c;
        if ((EXTB'(offx_c) + EXTB'(1)) >= eff_bs) begin
          offx_d = '0;
          idx_d  = idx_c + CW'(1);
        end else begin
          offx_d = offx_c + OW'(1);
          idx_d  = idx_c;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      idx_q  <= '0;
      offx_q <= '0;
      offy_q <= '0;
    end else begin
      col_q  <= col_d;
      idx_q  <= idx_d;
      offx_q <= offx_d;
      offy_q <= offy_d;
    end
  end

endmodule

`default_nettype wire

### rtl/bmp_back.sv
// Back part: held block color, line store access and result stage.
// Depends on bmp_pkg for the kind codes and on bmp_ram for the line store.
`default_nettype none

module bmp_back #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 mid_valid_i,
  input  wire  [$bits(bmp_pkg::kind_e)+$clog2(MAX_WIDTH)+bmp_pkg::PIXEL_W-1:0] mid_entry_i,
  output logic                mid_pop_o,
  input  wire  [$clog2(bmp_pkg::OUT_DEPTH+1)-1:0] out_count_i,
  output logic                out_push_o,
  output logic [31:0]         out_data_o
);

  import bmp_pkg::*;

  localparam int AW      = $clog2(MAX_WIDTH);
  localparam int KIND_W  = $bits(kind_e);
  localparam int ENTRY_W = KIND_W + AW + PIXEL_W;
  localparam int OCW     = $clog2(OUT_DEPTH+1);

  kind_e              kind;
  logic [AW-1:0]      slot;
  logic [PIXEL_W-1:0] pix;
  logic               adv;
  logic               ram_we, ram_re;
  logic [PIXEL_W-1:0] ram_rdata;
  logic [PIXEL_W-1:0] held_q, held_d;
  logic               b_valid_q;
  logic               b_use_ram_q, b_use_ram_d;
  logic [PIXEL_W-1:0] b_color_q, b_color_d;

  assign kind = kind_e'(mid_entry_i[ENTRY_W-1 -: KIND_W]);
  assign slot = mid_entry_i[PIXEL_W +: AW];
  assign pix  = mid_entry_i[PIXEL_W-1:0];

  // Take a pixel only when the result queue has room for everything in flight.
  assign adv = mid_valid_i &&
               ((OCW+1)'(out_count_i) + (OCW+1)'(b_valid_q) < (OCW+1)'(OUT_DEPTH));
  assign mid_pop_o = adv;

  // Carry out the classified operation.
  always_comb begin
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    held_d      = held_q;
    b_use_ram_d = 1'b0;
    b_color_d   = held_q;
    if (adv) begin
      case (kind)
        KIND_HEAD: begin
          ram_we    = 1'b1;
          held_d    = pix;
          b_color_d = pix;
        end
        KIND_FOLLOW: begin
          b_color_d = held_q;
        end
        KIND_READ: begin
          ram_re      = 1'b1;
          b_use_ram_d = 1'b1;
        end
        default: begin
          b_color_d = held_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      b_valid_q <= 1'b0;
    end else begin
      held_q    <= held_d;
      b_valid_q <= adv;
    end
  end

  always_ff @(posedge clk_i) begin
    b_use_ram_q <= b_use_ram_d;
    b_color_q   <= b_color_d;
  end

  // One block color per block column.
  bmp_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (pix),
    .re_i    (ram_re),
    .raddr_i (slot),
    .rdata_o (ram_rdata)
  );

  // The result stage always drains into the result queue.
  assign out_push_o = b_valid_q;
  assign out_data_o = b_use_ram_q ? ram_rdata : b_color_q;

endmodule

`default_nettype wire

### rtl/block_mosaic_pixelate.sv
// Mosaic pixelation of a 32-bit ARGB raster stream; one result per pixel.
// Each pixel goes through the mid queue, the result stage and the result queue.
// Throughput: one pixel per cycle while full is low, set by the single line-store
// read per pixel. The line store takes one write and one read port each cycle.
// Reset: counters and held color clear, block_size = 8, image_width = 640;
// the line store is not cleared and is valid once a block's first row wrote it.
`default_nettype none

module block_mosaic_pixelate #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_BLOCK = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Pixel input queue side
  input  wire         push,
  output logic        full,
  input  wire  [31:0] pixel_color_i,
  input  wire         frame_start_i,
  // Result queue side
  output logic        empty,
  input  wire         pop,
  output logic [31:0] out_color_o,
  // Configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import bmp_pkg::*;

  localparam int ENTRY_W = $bits(kind_e) + $clog2(MAX_WIDTH) + PIXEL_W;
  localparam int OCW     = $clog2(OUT_DEPTH+1);
  localparam int MCW     = $clog2(MID_DEPTH+1);

  cfg_t               cfg_q, cfg_d;
  logic               cfg_we;
  logic               in_accept;
  logic [ENTRY_W-1:0] front_entry, mid_entry;
  logic               mid_empty, mid_pop;
  logic [MCW-1:0]     mid_count;
  logic [OCW-1:0]     out_count;
  logic               out_push;
  logic [PIXEL_W-1:0] out_data;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (paddr[2])
        REG_BLOCK_SIZE:  cfg_d.block_size  = pwdata[6:0];
        REG_IMAGE_WIDTH: cfg_d.image_width = pwdata[11:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_size  <= BLOCK_SIZE_RESET;
      cfg_q.image_width <= IMAGE_WIDTH_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[2])
      REG_BLOCK_SIZE:  prdata = {25'd0, cfg_q.block_size};
      REG_IMAGE_WIDTH: prdata = {20'd0, cfg_q.image_width};
      default:         prdata = '0;
    endcase
  end

  // The input side is full when the queue to the back part is.
  assign full      = (mid_count == MCW'(MID_DEPTH));
  assign in_accept = push && !full;

  bmp_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .accept_i      (in_accept),
    .pixel_color_i (pixel_color_i),
    .frame_start_i (frame_start_i),
    .entry_o       (front_entry)
  );

  // Queue between the front and back parts.
  bmp_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (MID_DEPTH)
  ) u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .wdata_i (front_entry),
    .pop_i   (mid_pop),
    .rdata_o (mid_entry),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  bmp_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (!mid_empty),
    .mid_entry_i (mid_entry),
    .mid_pop_o   (mid_pop),
    .out_count_i (out_count),
    .out_push_o  (out_push),
    .out_data_o  (out_data)
  );

  // Result queue toward the consumer.
  bmp_fifo #(
    .WIDTH (PIXEL_W),
    .DEPTH (OUT_DEPTH)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_data),
    .pop_i   (pop),
    .rdata_o (out_color_o),
    .empty_o (empty),
    .count_o (out_count)
  );

endmodule

`default_nettype wire

### rtl/bmp_checker.sv
// Port-level checker for the mosaic pixelation block, bound to the top level.
// Depends on bmp_pkg for the queue depths.
`default_nettype none

module bmp_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        push,
  input wire        full,
  input wire [31:0] pixel_color_i,
  input wire        frame_start_i,
  input wire        empty,
  input wire        pop,
  input wire [31:0] out_color_o
);

  import bmp_pkg::*;

  logic       in_xfer, out_xfer;
  logic [3:0] pending_q, pending_d;
  logic       armed_q, armed_d;
  logic [31:0] fs_pix_q;

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;

  // Items transferred in whose results have not yet been transferred out.
  always_comb begin
    pending_d = pending_q;
    if (in_xfer && !out_xfer) begin
      pending_d = pending_q + 4'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_d = pending_q - 4'd1;
    end
  end

  // A frame-start pixel entering an empty block must come out unchanged, first.
  always_comb begin
    armed_d = armed_q;
    if (armed_q && out_xfer) begin
      armed_d = 1'b0;
    end
    if (in_xfer && frame_start_i && (pending_q == 4'd0)) begin
      armed_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      armed_q   <= 1'b0;
    end else begin
      pending_q <= pending_d;
      armed_q   <= armed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && frame_start_i && (pending_q == 4'd0)) begin
      fs_pix_q <= pixel_color_i;
    end
  end

  // No result is transferred without a pixel behind it.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> (pending_q != 4'd0))
    else $error("result transferred with no pixel pending");

  // With nothing pending the result side shows empty.
  a_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q == 4'd0) |-> empty)
    else $error("result shown with no pixel pending");

  // Input back-pressure only with the front queue really occupied.
  a_full_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> (pending_q >= 4'(MID_DEPTH)))
    else $error("full raised with too few pixels in flight");

  // A waiting result holds until it is taken.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_color_o)))
    else $error("waiting result changed or vanished");

  // The opening pixel of a frame is a block head and passes unchanged.
  a_frame_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (armed_q && !empty) |-> (out_color_o == fs_pix_q))
    else $error("frame-start pixel not passed through");

endmodule

bind block_mosaic_pixelate bmp_checker u_checker (.*);

`default_nettype wire

### tb/block_mosaic_pixelate_tb.sv
// Self-checking testbench for the mosaic pixelation block.
// Depends on bmp_pkg and block_mosaic_pixelate; it carries its own mosaic predictor.
`timescale 1ns / 100ps

module block_mosaic_pixelate_tb;
  import bmp_pkg::*;

  localparam int MAX_WIDTH = 2048;
  localparam int MAX_BLOCK = 64;
  localparam int RANDOM_PIXELS = 1500;

  // Byte addresses of the two configuration registers.
  localparam logic [2:0] ADDR_BLOCK_SIZE  = {REG_BLOCK_SIZE, 2'b00};
  localparam logic [2:0] ADDR_IMAGE_WIDTH = {REG_IMAGE_WIDTH, 2'b00};

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] pixel_color_i = '0;
  logic        frame_start_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] out_color_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  block_mosaic_pixelate u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .pixel_color_i (pixel_color_i),
    .frame_start_i (frame_start_i),
    .empty         (empty),
    .pop           (pop),
    .out_color_o   (out_color_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Run bookkeeping.
  int          err_count = 0;
  int          pixels_sent = 0;
  int          send_idle_pct = 30;
  int          pop_idle_pct = 30;
  int          pop_stall = 0;
  bit          quiet = 1'b0;
  logic [31:0] want_color;
  logic [31:0] pending_colors_q[$];

  // Predictor copy of the configuration registers.
  logic [6:0]  cur_block_size = BLOCK_SIZE_RESET;
  logic [11:0] cur_image_width = IMAGE_WIDTH_RESET;

  // Predictor copy of the raster position and color storage.
  logic [10:0] px_col = '0;
  logic [5:0]  px_off_x = '0;
  logic [5:0]  px_off_y = '0;
  logic [10:0] px_blk_col = '0;
  logic [31:0] px_held = '0;
  logic [31:0] px_line [MAX_WIDTH];

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%0t ERROR: %s", $realtime, msg);
  endfunction

  // Block size and width as the block applies them after clamping.
  function automatic int unsigned eff_block_size();
    if (cur_block_size == 0) return 1;
    if (cur_block_size > MAX_BLOCK) return MAX_BLOCK;
    return cur_block_size;
  endfunction

  function automatic int unsigned eff_image_width();
    if (cur_image_width == 0) return 1;
    if (cur_image_width > MAX_WIDTH) return MAX_WIDTH;
    return cur_image_width;
  endfunction

  // Predicts the output color of one pixel and advances the raster position.
  function automatic logic [31:0] mosaic_color(input logic [31:0] pix, input logic fs);
    int unsigned eb;
    int unsigned ew;
    logic [31:0] color;
    eb = eff_block_size();
    ew = eff_image_width();
    if (fs) begin
      px_col = '0;
      px_off_x = '0;
      px_off_y = '0;
      px_blk_col = '0;
    end
    // The first row of a block holds its top-left color; later rows read the line store.
    if (px_off_y == 0) begin
      if (px_off_x == 0) begin
        px_held = pix;
        px_line[px_blk_col] = pix;
      end
      color = px_held;
    end else begin
      color = px_line[px_blk_col];
    end
    // Counters at or past a limit wrap at this advance.
    if (px_col + 32'd1 >= ew) begin
      px_col = '0;
      px_off_x = '0;
      px_blk_col = '0;
      if (px_off_y + 32'd1 >= eb) px_off_y = '0;
      else px_off_y = px_off_y + 6'd1;
    end else begin
      px_col = px_col + 11'd1;
      if (px_off_x + 32'd1 >= eb) begin
        px_off_x = '0;
        px_blk_col = px_blk_col + 11'd1;
      end else begin
        px_off_x = px_off_x + 6'd1;
      end
    end
    return color;
  endfunction

  function automatic logic [31:0] random_pixel();
    case ($urandom_range(0, 15))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Result side: check each transfer against the oldest prediction, then pick pop.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (pending_colors_q.size() == 0) begin
          flag_error($sformatf("result %08h with no pixel pending", out_color_o));
        end else begin
          want_color = pending_colors_q.pop_front();
          if (out_color_o !== want_color)
            flag_error($sformatf("out_color expected %08h, got %08h", want_color, out_color_o));
        end
      end
      if (pop_stall > 0) begin
        pop <= 1'b0;
        pop_stall--;
      end else if (!quiet && $urandom_range(0, 99) < pop_idle_pct) begin
        pop <= 1'b0;
        pop_stall = $urandom_range(0, 3);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Offers one pixel, waits for its transfer and records the predicted color.
  task automatic send_pixel(input logic [31:0] pix, input logic fs);
    push <= 1'b1;
    pixel_color_i <= pix;
    frame_start_i <= fs;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pending_colors_q.push_back(mosaic_color(pix, fs));
    pixels_sent++;
    if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Stops offering pixels and waits until every predicted color has come back.
  task automatic wait_drained();
    push <= 1'b0;
    while (pending_colors_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_transfer(input logic wr, input logic [2:0] addr,
                              input logic [31:0] data, output logic [31:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Register write, only once the block is idle; mirrors it into the predictor.
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] rd;
    wait_drained();
    apb_transfer(1'b1, addr, data, rd);
    if (addr == ADDR_BLOCK_SIZE) cur_block_size = data[6:0];
    else cur_image_width = data[11:0];
  endtask

  task automatic set_mosaic(input logic [6:0] bs, input logic [11:0] w);
    reg_write(ADDR_BLOCK_SIZE, {25'd0, bs});
    reg_write(ADDR_IMAGE_WIDTH, {20'd0, w});
  endtask

  // Reset values read back, then a block head and a follower at reset settings.
  task automatic test_reset_config();
    logic [31:0] rd;
    apb_transfer(1'b0, ADDR_BLOCK_SIZE, '0, rd);
    if (rd !== {25'd0, BLOCK_SIZE_RESET})
      flag_error($sformatf("block_size reads %08h after reset", rd));
    apb_transfer(1'b0, ADDR_IMAGE_WIDTH, '0, rd);
    if (rd !== {20'd0, IMAGE_WIDTH_RESET})
      flag_error($sformatf("image_width reads %08h after reset", rd));
    send_pixel(32'h0000_0000, 1'b1);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    wait_drained();
  endtask

  // One full line at the widest frame with one-pixel blocks writes every line store
  // entry, so no later setting can make a read of an entry never written.
  task automatic test_full_line_fill();
    set_mosaic(7'd0, 12'd2048);
    for (int i = 0; i < MAX_WIDTH + 3; i++) send_pixel(random_pixel(), i == 0);
    wait_drained();
  endtask

  // Width above the maximum acts as the maximum; the second row reads back.
  task automatic test_oversized_width();
    set_mosaic(7'd127, 12'hFFF);
    for (int i = 0; i < MAX_WIDTH + 70; i++) send_pixel(random_pixel(), i == 0);
    wait_drained();
  endtask

  // Small frame where both the last block column and the last block row are partial.
  task automatic test_partial_blocks();
    set_mosaic(7'd2, 12'd3);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    for (int i = 1; i < 9; i++) send_pixel(random_pixel(), 1'b0);
  endtask

  // A frame start in the middle of a row restarts the block pattern.
  task automatic test_frame_restart();
    for (int i = 0; i < 4; i++) send_pixel(random_pixel(), i == 0);
    send_pixel(random_pixel(), 1'b1);
    send_pixel(random_pixel(), 1'b0);
    send_pixel(random_pixel(), 1'b0);
  endtask

  // Zero size and zero width act as one; an oversized block acts as the maximum.
  task automatic test_clamped_settings();
    set_mosaic(7'd0, 12'd0);
    for (int i = 0; i < 3; i++) send_pixel(random_pixel(), i == 0);
    set_mosaic(7'd127, 12'd2);
    for (int i = 0; i < 4; i++) send_pixel(random_pixel(), i == 0);
  endtask

  // Width shrinks under a running frame; the column counter wraps at the next advance.
  task automatic test_mid_frame_change();
    set_mosaic(7'd2, 12'd3);
    for (int i = 0; i < 4; i++) send_pixel(random_pixel(), i == 0);
    reg_write(ADDR_IMAGE_WIDTH, 32'd1);
    for (int i = 0; i < 3; i++) send_pixel(random_pixel(), 1'b0);
    wait_drained();
  endtask

  // Random frames under random settings, mostly opened by a frame start.
  task automatic test_random_frames(input int target);
    int          first;
    int          n;
    int unsigned eb;
    int unsigned ew;
    logic [6:0]  bs;
    logic [11:0] w;
    logic        fs;
    first = pixels_sent;
    while (pixels_sent - first < target) begin
      wait_drained();
      if (pixels_sent - first > target * 4 / 5) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0: bs = 7'd0;
        1: bs = 7'd127;
        2: bs = 7'd64;
        3: bs = 7'($urandom_range(65, 126));
        default: bs = 7'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 9))
        0: w = 12'd0;
        1: w = 12'd1;
        default: w = 12'($urandom_range(2, 48));
      endcase
      // Sometimes the settings stay, so the frame may run on without a restart.
      if ($urandom_range(0, 3) != 0) set_mosaic(bs, w);
      eb = eff_block_size();
      ew = eff_image_width();
      n = ew * $urandom_range(1, 2 * eb + 1);
      if (n > 300) n = 300;
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
      send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      pop_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      for (int i = 0; i < n; i++) begin
        fs = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
        send_pixel(random_pixel(), fs);
      end
    end
  endtask

  // Test sequence.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_full_line_fill();
    test_partial_blocks();
    test_frame_restart();
    test_clamped_settings();
    test_mid_frame_change();
    test_oversized_width();
    test_random_frames(RANDOM_PIXELS);
    quiet = 1'b1;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
